// ----- hdl/crcc_pkg.sv -----
// Shared types, constants and register codes for the CRC codeword stream checker.
package crcc_pkg;

    // Default sizing
    localparam int MAX_GEN_LEN = 16;
    localparam int COUNT_WIDTH = 32;

    // Fixed field widths
    localparam int GEN_BITS_W = 16;
    localparam int GEN_LEN_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TOTAL_W    = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DW_MODE  = 2'd2;

    // Register reset values
    localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = 16'd11;
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 5'd4;
    localparam logic                  DW_MODE_RST  = 1'b0;

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue depth, in per-word slots
    localparam int RESQ_DEPTH = 2;

    // Configuration register set
    typedef struct packed {
        logic [GEN_BITS_W-1:0] gen_bits;
        logic [GEN_LEN_W-1:0]  gen_len;
        logic                  dw_mode;
    } t_cfg;

    // All results caused by one input word
    typedef struct packed {
        logic               has_data;
        logic [7:0]         data;
        logic               has_sum;
        logic [TOTAL_W-1:0] cw_total;
        logic [TOTAL_W-1:0] er_total;
        logic               pad;
    } t_slot;

endpackage

// ----- hdl/crcc_core.sv -----
// Stream state and the unrolled eight-bit CRC division step for one input word.
module crcc_core #(
    parameter int MAX_GEN_LEN = crcc_pkg::MAX_GEN_LEN,
    parameter int COUNT_WIDTH = crcc_pkg::COUNT_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crcc_pkg::t_cfg      i_cfg,
    input  logic                i_cfg_clear,
    input  logic                i_accept,
    input  logic [7:0]          i_stream_byte,
    input  logic                i_final_byte,
    output logic                o_slot_valid,
    output crcc_pkg::t_slot     o_slot
);

    localparam int LW = $clog2(MAX_GEN_LEN + 1);
    localparam int IW = $clog2(MAX_GEN_LEN + 8);

    // Saturating add of 0..2 to a counter
    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] v,
                                                       input logic [1:0] inc);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, v} + (COUNT_WIDTH + 1)'(inc);
        if (s[COUNT_WIDTH]) begin
            return '1;
        end
        return s[COUNT_WIDTH-1:0];
    endfunction

    // Clip a counter to the 32-bit report width
    function automatic logic [crcc_pkg::TOTAL_W-1:0] clip32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        if (e > 64'h0000_0000_FFFF_FFFF) begin
            return '1;
        end
        return e[crcc_pkg::TOTAL_W-1:0];
    endfunction

    // Stream state
    logic                   r_header_done, n_header_done;
    logic [2:0]             r_skip,        n_skip;
    logic                   r_pad,         n_pad;
    logic [MAX_GEN_LEN-1:0] r_win,         n_win;
    logic [IW-1:0]          r_idx,         n_idx;
    logic [7:0]             r_dw,          n_dw;
    logic [3:0]             r_acc,         n_acc;
    logic                   r_half,        n_half;
    logic [COUNT_WIDTH-1:0] r_cw_cnt,      n_cw_cnt;
    logic [COUNT_WIDTH-1:0] r_er_cnt,      n_er_cnt;

    // Generator shape derived from the registers
    logic [LW-1:0]          l_eff;
    logic [3:0]             d_eff;
    logic [IW-1:0]          n_len;
    logic [MAX_GEN_LEN-1:0] lmask, msel, rmask, gen;

    always_comb begin
        if (i_cfg.gen_len == '0) begin
            l_eff = LW'(1);
        end else if (int'(i_cfg.gen_len) > MAX_GEN_LEN) begin
            l_eff = LW'(MAX_GEN_LEN);
        end else begin
            l_eff = LW'(i_cfg.gen_len);
        end
        d_eff = i_cfg.dw_mode ? 4'd8 : 4'd4;
        n_len = IW'(d_eff) + IW'(l_eff) - IW'(1);
        for (int j = 0; j < MAX_GEN_LEN; j++) begin
            lmask[j] = (j < int'(l_eff));
            msel[j]  = (j == int'(l_eff) - 1);
        end
        rmask = lmask & ~msel;
        gen   = MAX_GEN_LEN'(i_cfg.gen_bits) & lmask;
    end

    // Per-word working values
    logic [MAX_GEN_LEN-1:0] w;
    logic                   b;
    logic                   emit;
    logic [7:0]             odata;
    logic [1:0]             cw_inc, er_inc;

    // Header decode or eight division steps, MSB first
    always_comb begin
        n_header_done = r_header_done;
        n_skip        = r_skip;
        n_pad         = r_pad;
        n_win         = r_win;
        n_idx         = r_idx;
        n_dw          = r_dw;
        n_acc         = r_acc;
        n_half        = r_half;
        emit          = 1'b0;
        odata         = 8'd0;
        cw_inc        = 2'd0;
        er_inc        = 2'd0;
        w             = '0;
        b             = 1'b0;
        if (!r_header_done) begin
            n_header_done = 1'b1;
            if (|i_stream_byte[7:3]) begin
                n_pad  = 1'b1;
                n_skip = 3'd0;
            end else begin
                n_skip = i_stream_byte[2:0];
            end
        end else begin
            for (int i = 7; i >= 0; i--) begin
                b = i_stream_byte[i];
                if (n_skip != 3'd0) begin
                    n_skip = n_skip - 3'd1;
                end else begin
                    if (n_idx < IW'(d_eff)) begin
                        n_dw = {n_dw[6:0], b};
                    end
                    w = ((n_win << 1) | MAX_GEN_LEN'(b)) & lmask;
                    if ((w & msel) != '0) begin
                        w = w ^ gen;
                    end
                    n_win = w & rmask;
                    n_idx = n_idx + IW'(1);
                    // codeword complete: count, check, pack dataword
                    if (n_idx == n_len) begin
                        cw_inc = cw_inc + 2'd1;
                        if (n_win != '0) begin
                            er_inc = er_inc + 2'd1;
                        end
                        if (!i_cfg.dw_mode) begin
                            if (n_half) begin
                                if (!emit) begin
                                    odata = {n_acc, n_dw[3:0]};
                                end
                                emit   = 1'b1;
                                n_half = 1'b0;
                            end else begin
                                n_acc  = n_dw[3:0];
                                n_half = 1'b1;
                            end
                        end else begin
                            if (!emit) begin
                                odata = n_half ? {n_acc, n_dw[7:4]} : n_dw;
                            end
                            emit  = 1'b1;
                            n_acc = n_dw[3:0];
                        end
                        n_idx = '0;
                        n_win = '0;
                        n_dw  = 8'd0;
                    end
                end
            end
        end
        n_cw_cnt = sat_add(r_cw_cnt, cw_inc);
        n_er_cnt = sat_add(r_er_cnt, er_inc);
    end

    // Results for this word
    always_comb begin
        o_slot_valid      = emit | i_final_byte;
        o_slot.has_data   = emit;
        o_slot.data       = odata;
        o_slot.has_sum    = i_final_byte;
        o_slot.cw_total   = clip32(n_cw_cnt);
        o_slot.er_total   = clip32(n_er_cnt);
        o_slot.pad        = n_pad;
    end

    // State update; a final word rearms the stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_done <= 1'b0;
            r_skip        <= 3'd0;
            r_pad         <= 1'b0;
            r_win         <= '0;
            r_idx         <= '0;
            r_dw          <= 8'd0;
            r_acc         <= 4'd0;
            r_half        <= 1'b0;
            r_cw_cnt      <= '0;
            r_er_cnt      <= '0;
        end else if (i_cfg_clear) begin
            r_win <= '0;
            r_idx <= '0;
            r_dw  <= 8'd0;
        end else if (i_accept) begin
            if (i_final_byte) begin
                r_header_done <= 1'b0;
                r_skip        <= 3'd0;
                r_pad         <= 1'b0;
                r_win         <= '0;
                r_idx         <= '0;
                r_dw          <= 8'd0;
                r_acc         <= 4'd0;
                r_half        <= 1'b0;
                r_cw_cnt      <= '0;
                r_er_cnt      <= '0;
            end else begin
                r_header_done <= n_header_done;
                r_skip        <= n_skip;
                r_pad         <= n_pad;
                r_win         <= n_win;
                r_idx         <= n_idx;
                r_dw          <= n_dw;
                r_acc         <= n_acc;
                r_half        <= n_half;
                r_cw_cnt      <= n_cw_cnt;
                r_er_cnt      <= n_er_cnt;
            end
        end
    end

endmodule

// ----- hdl/crcc_resq.sv -----
// Result queue: holds per-word result slots and plays them out one result at a time.
module crcc_resq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  crcc_pkg::t_slot               i_slot,
    output logic                          o_not_full,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic [7:0]                    o_data_byte,
    output logic [crcc_pkg::TOTAL_W-1:0]  o_codeword_total,
    output logic [crcc_pkg::TOTAL_W-1:0]  o_error_total,
    output logic                          o_padding_fault,
    output logic                          o_run_end
);

    localparam int PW = $clog2(crcc_pkg::RESQ_DEPTH);
    localparam int CW = $clog2(crcc_pkg::RESQ_DEPTH + 1);

    crcc_pkg::t_slot r_slot [crcc_pkg::RESQ_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            r_phase;   // data result of head slot already taken

    crcc_pkg::t_slot head;
    logic            show_data;
    logic            out_take;
    logic            pop;

    // Head slot decode
    always_comb begin
        head          = r_slot[r_rptr];
        show_data     = head.has_data & ~r_phase;
        o_out_valid   = (r_count != '0);
        o_not_full    = (r_count != CW'(crcc_pkg::RESQ_DEPTH));
        o_result_kind = show_data ? crcc_pkg::KIND_DATA : crcc_pkg::KIND_SUMMARY;
        o_data_byte   = show_data ? head.data : 8'd0;
        o_codeword_total = show_data ? '0 : head.cw_total;
        o_error_total    = show_data ? '0 : head.er_total;
        o_padding_fault  = head.pad;
        o_run_end        = show_data ? ~head.has_sum : 1'b1;
        out_take         = o_out_valid & i_out_ready;
        pop              = out_take & o_run_end;
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_slot;
        end
    end

    // Pointers, fill count and head phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_phase <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wptr <= (int'(r_wptr) == crcc_pkg::RESQ_DEPTH - 1) ? '0 : r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= (int'(r_rptr) == crcc_pkg::RESQ_DEPTH - 1) ? '0 : r_rptr + PW'(1);
            end
            r_count <= r_count + CW'(i_wr) - CW'(pop);
            if (out_take) begin
                r_phase <= ~pop;
            end
        end
    end

endmodule

// ----- hdl/crc_codeword_stream_checker_top.sv -----
// Top level of the CRC codeword stream checker: registers, core and result queue.
//
//  channel  direction  handshake                 payload
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//  in       in         i_in_valid / o_in_ready    i_stream_byte, i_final_byte
//  out      out        o_out_valid / i_out_ready  o_result_kind .. o_run_end
//
// One input word is taken per cycle while o_in_ready is high; its results are registered into the result queue.
// A word yields 0, 1 or 2 results; the out side moves one result per cycle while i_out_ready is high,
// so a word with both a data byte and a summary gives the data result first and then the summary.
// o_in_ready drops while both result-queue slots are occupied or a register write is offered.
// Reset is synchronous; it restores registers to 11, 4, 0 and clears the stream.
// Configuration writes are always taken; a write to a real register discards the
// codeword in progress.
module crc_codeword_stream_checker_top #(
    parameter int MAX_GEN_LEN = crcc_pkg::MAX_GEN_LEN,
    parameter int COUNT_WIDTH = crcc_pkg::COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_stream_byte,
    input  logic                            i_final_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [7:0]                      o_data_byte,
    output logic [crcc_pkg::TOTAL_W-1:0]    o_codeword_total,
    output logic [crcc_pkg::TOTAL_W-1:0]    o_error_total,
    output logic                            o_padding_fault,
    output logic                            o_run_end
);

    crcc_pkg::t_cfg  r_cfg;
    crcc_pkg::t_slot slot;
    logic            slot_valid;
    logic            cfg_wr;
    logic            cfg_hit;
    logic            in_accept;
    logic            not_full;

    // A register write takes the cycle; no stream word is taken alongside it
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign o_in_ready  = not_full & ~i_cfg_valid;
    assign in_accept   = i_in_valid & o_in_ready;

    // Register index decode
    always_comb begin
        unique case (i_cfg_index)
            crcc_pkg::CFG_GEN_BITS,
            crcc_pkg::CFG_GEN_LEN,
            crcc_pkg::CFG_DW_MODE: cfg_hit = 1'b1;
            default:               cfg_hit = 1'b0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gen_bits <= crcc_pkg::GEN_BITS_RST;
            r_cfg.gen_len  <= crcc_pkg::GEN_LEN_RST;
            r_cfg.dw_mode  <= crcc_pkg::DW_MODE_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                crcc_pkg::CFG_GEN_BITS: r_cfg.gen_bits <= i_cfg_data;
                crcc_pkg::CFG_GEN_LEN:  r_cfg.gen_len  <= i_cfg_data[crcc_pkg::GEN_LEN_W-1:0];
                crcc_pkg::CFG_DW_MODE:  r_cfg.dw_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    crcc_core #(
        .MAX_GEN_LEN (MAX_GEN_LEN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cfg_clear   (cfg_wr & cfg_hit),
        .i_accept      (in_accept),
        .i_stream_byte (i_stream_byte),
        .i_final_byte  (i_final_byte),
        .o_slot_valid  (slot_valid),
        .o_slot        (slot)
    );

    crcc_resq u_resq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr             (in_accept & slot_valid),
        .i_slot           (slot),
        .o_not_full       (not_full),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_data_byte      (o_data_byte),
        .o_codeword_total (o_codeword_total),
        .o_error_total    (o_error_total),
        .o_padding_fault  (o_padding_fault),
        .o_run_end        (o_run_end)
    );

endmodule
